@@ hdl/itda_pkg.sv @@
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants and sizing helpers for the integer to decimal text block.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int VALUE_BITS_DEF = 32;

  // Magnitude bits folded into the BCD register per converter cycle
  localparam int DABBLE_BITS = 4;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Decimal digits needed for 2**bits - 1; 1233/4096 approximates log10(2)
  function automatic int dec_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  // Converter cycles for a magnitude of the given width
  function automatic int num_steps(input int bits);
    return (bits + DABBLE_BITS - 1) / DABBLE_BITS;
  endfunction

endpackage

@@ hdl/itda_front.sv @@
// ----------------------------------------------------------------------------
// itda_front
// Input side: takes a signed word and splits it into sign and magnitude.
// ----------------------------------------------------------------------------
module itda_front #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  push,
  input  logic                  push_ready,
  output logic [VALUE_BITS:0]   push_data   // {negative, magnitude}
);

  logic                  negative;
  logic [VALUE_BITS-1:0] magnitude;

  // Two's complement negate; the most negative value maps onto its unsigned magnitude
  assign negative  = value[VALUE_BITS-1];
  assign magnitude = negative ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

  assign s_tready  = push_ready;
  assign push      = s_tvalid & push_ready;
  assign push_data = {negative, magnitude};

endmodule

@@ hdl/itda_queue.sv @@
// ----------------------------------------------------------------------------
// itda_queue
// Short FIFO that decouples the front from the converter.
// ----------------------------------------------------------------------------
module itda_queue #(
  parameter int WIDTH = itda_pkg::VALUE_BITS_DEF + 1,
  parameter int DEPTH = itda_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ hdl/itda_conv.sv @@
// ----------------------------------------------------------------------------
// itda_conv
// Binary to BCD converter: shift-and-add-3, several magnitude bits a cycle.
// ----------------------------------------------------------------------------
module itda_conv #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [VALUE_BITS:0]   q_data,    // {negative, magnitude}
  output logic                  c_valid,
  input  logic                  c_ready,
  output logic                  c_neg,
  output logic [itda_pkg::dec_digits(VALUE_BITS)*4-1:0] c_bcd
);

  localparam int NDIG  = itda_pkg::dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * 4;
  localparam int NSTEP = itda_pkg::num_steps(VALUE_BITS);
  localparam int PADW  = NSTEP * itda_pkg::DABBLE_BITS;
  localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } conv_state_t;

  conv_state_t      state;
  logic [CNT_W-1:0] cnt;
  logic [PADW-1:0]  mag_sr;
  logic [BCD_W-1:0] bcd;
  logic             neg;
  logic [PADW-1:0]  mag_next;
  logic [BCD_W-1:0] bcd_next;
  logic             load;
  logic             bcd_ok;

  assign q_ready = (state == S_IDLE) || ((state == S_DONE) && c_ready);
  assign load    = q_valid && q_ready;
  assign c_valid = (state == S_DONE);
  assign c_neg   = neg;
  assign c_bcd   = bcd;

  // One converter cycle: for each of its magnitude bits, adjust every digit,
  // then shift that bit in
  always_comb begin
    logic [BCD_W-1:0] b_t;
    logic [PADW-1:0]  m_t;
    b_t = bcd;
    m_t = mag_sr;
    for (int k = 0; k < itda_pkg::DABBLE_BITS; k++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (b_t[i*4 +: 4] >= 4'd5) begin
          b_t[i*4 +: 4] = b_t[i*4 +: 4] + 4'd3;
        end
      end
      {b_t, m_t} = {b_t[BCD_W-2:0], m_t, 1'b0};
    end
    bcd_next = b_t;
    mag_next = m_t;
  end

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_sr <= PADW'(q_data[VALUE_BITS-1:0]);
      bcd    <= '0;
      neg    <= q_data[VALUE_BITS];
      cnt    <= CNT_W'(NSTEP - 1);
    end else if (state == S_RUN) begin
      mag_sr <= mag_next;
      bcd    <= bcd_next;
      cnt    <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) state <= S_RUN;
        end
        S_RUN: begin
          if (cnt == '0) state <= S_DONE;
        end
        S_DONE: begin
          // take the next magnitude in the same cycle the result leaves
          if (c_ready) state <= q_valid ? S_RUN : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && (cnt == '0) |=> (state == S_DONE))
    else $error("conversion did not finish after the last step");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> bcd_ok)
    else $error("converted digit out of decimal range");

endmodule

@@ hdl/itda_emit.sv @@
// ----------------------------------------------------------------------------
// itda_emit
// Character sequencer: sign, then digits from the leading nonzero one down.
// ----------------------------------------------------------------------------
module itda_emit #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_neg,
  input  logic [itda_pkg::dec_digits(VALUE_BITS)*4-1:0] in_bcd,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_code
  output logic       m_tlast    // last
);

  localparam int NDIG  = itda_pkg::dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * 4;
  localparam int IDX_W = $clog2(NDIG);

  logic             busy;
  logic             sign_pend;
  logic [IDX_W-1:0] idx;
  logic [BCD_W-1:0] bcd;
  logic [3:0]       dig [NDIG];
  logic [IDX_W-1:0] msd;
  logic [3:0]       cur;
  logic             last_char;
  logic             load;

  // Highest nonzero digit; zero keeps index 0 and gives a single "0"
  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (in_bcd[i*4 +: 4] != 4'd0) begin
        msd = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig[i] = bcd[i*4 +: 4];
    end
  end

  assign cur       = dig[idx];
  assign last_char = !sign_pend && (idx == '0);
  assign in_ready  = !busy || (m_tready && last_char);
  assign load      = in_valid && in_ready;

  assign m_tvalid = busy;
  assign m_tdata  = sign_pend ? itda_pkg::CHAR_MINUS : (itda_pkg::CHAR_ZERO + {4'd0, cur});
  assign m_tlast  = last_char;

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= in_bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      idx       <= '0;
    end else begin
      priority if (load) begin
        busy      <= 1'b1;
        sign_pend <= in_neg;
        idx       <= msd;
      end else if (busy && m_tready) begin
        // advance one word
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (idx == '0) begin
          busy <= 1'b0;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !in_valid |=> !m_tvalid)
    else $error("word sent after the last character");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    load && in_neg |=> m_tvalid && (m_tdata == itda_pkg::CHAR_MINUS))
    else $error("negative number did not open with a minus sign");

endmodule

@@ hdl/int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character word per output beat.
// ----------------------------------------------------------------------------
// Each input word is a two's complement integer; the output is its decimal
// text, most significant character first: '-' for negative values, then the
// digits without leading zeros, with tlast on the final character. Zero gives
// "0" and the most negative value gives its full magnitude. Accepted words
// wait in a two-entry queue while a shift-and-add-3 converter folds four
// magnitude bits per cycle, overlapped with the character sequencer of the
// previous number, so a new number can be converted before the last one has
// been sent. The throughput is set by the converter steps or by the output
// sending one character per cycle while m_tready is held high.
module int_to_decimal_ascii #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // [VALUE_BITS-1:0] value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] char_code
  output logic                              m_tlast    // last
);

  localparam int NDIG  = itda_pkg::dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * 4;

  logic                  push;
  logic                  push_ready;
  logic [VALUE_BITS:0]   push_data;
  logic                  q_valid;
  logic                  q_ready;
  logic [VALUE_BITS:0]   q_data;
  logic                  c_valid;
  logic                  c_ready;
  logic                  c_neg;
  logic [BCD_W-1:0]      c_bcd;

  itda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .value      (s_tdata[VALUE_BITS-1:0]),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  itda_queue #(
    .WIDTH (VALUE_BITS + 1),
    .DEPTH (itda_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_ready),
    .pop_data   (q_data)
  );

  itda_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .c_valid (c_valid),
    .c_ready (c_ready),
    .c_neg   (c_neg),
    .c_bcd   (c_bcd)
  );

  itda_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid),
    .in_ready (c_ready),
    .in_neg   (c_neg),
    .in_bcd   (c_bcd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
